// ===== sv/gpio_interrupt_controller_defines.svh =====
// assertion macros for the gpio interrupt controller checker
// no dependencies; included by files that carry assertions
`ifndef GPIO_INTERRUPT_CONTROLLER_DEFINES_SVH
`define GPIO_INTERRUPT_CONTROLLER_DEFINES_SVH

// same-cycle implication, held off during reset
`define GPIOIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpio interrupt controller check failed");

// next-cycle implication, held off during reset
`define GPIOIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpio interrupt controller check failed");

`endif

// ===== sv/gpioic_pkg.sv =====
// shared types, register map and helpers for the gpio interrupt controller
// no dependencies
`timescale 1ns / 1ps

package gpioic_pkg;

    localparam int PIN_COUNT_DEF = 32;
    localparam int DATA_W        = 32;
    localparam int HALF_W        = 16;
    localparam int WORD_W        = 5;
    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // register word offsets (byte offset / 4)
    localparam logic [WORD_W-1:0] REG_EN_L     = 5'd4;
    localparam logic [WORD_W-1:0] REG_EN_H     = 5'd5;
    localparam logic [WORD_W-1:0] REG_MASK_L   = 5'd6;
    localparam logic [WORD_W-1:0] REG_MASK_H   = 5'd7;
    localparam logic [WORD_W-1:0] REG_TYPE_L   = 5'd8;
    localparam logic [WORD_W-1:0] REG_TYPE_H   = 5'd9;
    localparam logic [WORD_W-1:0] REG_POL_L    = 5'd10;
    localparam logic [WORD_W-1:0] REG_POL_H    = 5'd11;
    localparam logic [WORD_W-1:0] REG_BOTH_L   = 5'd12;
    localparam logic [WORD_W-1:0] REG_BOTH_H   = 5'd13;
    localparam logic [WORD_W-1:0] REG_STATUS   = 5'd20;
    localparam logic [WORD_W-1:0] REG_RAW      = 5'd22;
    localparam logic [WORD_W-1:0] REG_EOI_L    = 5'd24;
    localparam logic [WORD_W-1:0] REG_EOI_H    = 5'd25;
    localparam logic [WORD_W-1:0] REG_EXT_PORT = 5'd28;

    typedef struct packed {
        cmd_t              command;
        logic [WORD_W-1:0] reg_word;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_line;
    } rsp_t;

    // one half of a split register, right aligned
    function automatic logic [DATA_W-1:0] half_read(input logic [DATA_W-1:0] r,
                                                    input logic hi);
        logic [DATA_W-1:0] res;
        res = hi ? {{HALF_W{1'b0}}, r[DATA_W-1:HALF_W]}
                 : {{HALF_W{1'b0}}, r[HALF_W-1:0]};
        return res;
    endfunction

endpackage

// ===== sv/gpioic_core.sv =====
// register file and pin detection logic of the gpio interrupt controller
// depends on gpioic_pkg
`timescale 1ns / 1ps

module gpioic_core #(
    parameter int PIN_COUNT = gpioic_pkg::PIN_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_fire,
    input  gpioic_pkg::req_t  req,
    output gpioic_pkg::rsp_t  rsp
);
    import gpioic_pkg::*;

    logic [PIN_COUNT-1:0] enable_reg, enable_next;
    logic [PIN_COUNT-1:0] mask_reg, mask_next;
    logic [PIN_COUNT-1:0] type_reg, type_next;
    logic [PIN_COUNT-1:0] pol_reg, pol_next;
    logic [PIN_COUNT-1:0] both_reg, both_next;
    logic [PIN_COUNT-1:0] raw_reg, raw_next;
    logic [PIN_COUNT-1:0] last_reg, last_next;

    logic [DATA_W-1:0]    sel32, val32;
    logic [PIN_COUNT-1:0] sel, val;
    logic [PIN_COUNT-1:0] cur, rise, fall, edge_hit, edge_pins, level_pins, level_on;
    logic [PIN_COUNT-1:0] sample_raw;
    logic [DATA_W-1:0]    rd;
    logic                 hi;

    // half-register write: upper 16 bits enable the lower 16
    assign hi    = req.reg_word[0];
    assign sel32 = hi ? {req.write_data[DATA_W-1:HALF_W], {HALF_W{1'b0}}}
                      : {{HALF_W{1'b0}}, req.write_data[DATA_W-1:HALF_W]};
    assign val32 = hi ? {req.write_data[DATA_W-1:HALF_W] & req.write_data[HALF_W-1:0],
                         {HALF_W{1'b0}}}
                      : {{HALF_W{1'b0}},
                         req.write_data[DATA_W-1:HALF_W] & req.write_data[HALF_W-1:0]};
    assign sel   = sel32[PIN_COUNT-1:0];
    assign val   = val32[PIN_COUNT-1:0];

    // sample detection
    assign cur        = req.pin_levels[PIN_COUNT-1:0];
    assign rise       = cur & ~last_reg;
    assign fall       = ~cur & last_reg;
    assign edge_hit   = (rise & pol_reg) | (fall & ~pol_reg);
    assign edge_pins  = type_reg & ~both_reg;
    assign level_pins = ~type_reg & ~both_reg;
    assign level_on   = ~(cur ^ pol_reg);
    assign sample_raw = ((raw_reg | (both_reg & (rise | fall)) | (edge_pins & edge_hit))
                         & ~level_pins) | (level_pins & level_on);

    always_comb begin
        enable_next = enable_reg;
        mask_next   = mask_reg;
        type_next   = type_reg;
        pol_next    = pol_reg;
        both_next   = both_reg;
        raw_next    = raw_reg;
        last_next   = last_reg;
        rd          = '0;
        case (req.command)
            CMD_WRITE: begin
                case (req.reg_word)
                    REG_EN_L, REG_EN_H: begin
                        enable_next = (enable_reg & ~sel) | val;
                        raw_next    = raw_reg & ((enable_reg & ~sel) | val);
                    end
                    REG_MASK_L, REG_MASK_H: mask_next = (mask_reg & ~sel) | val;
                    REG_TYPE_L, REG_TYPE_H: type_next = (type_reg & ~sel) | val;
                    REG_POL_L, REG_POL_H:   pol_next  = (pol_reg & ~sel) | val;
                    REG_BOTH_L, REG_BOTH_H: both_next = (both_reg & ~sel) | val;
                    REG_EOI_L, REG_EOI_H:   raw_next  = raw_reg & ~(val & (type_reg | both_reg));
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (req.reg_word)
                    REG_EN_L, REG_EN_H:     rd = half_read(DATA_W'(enable_reg), hi);
                    REG_MASK_L, REG_MASK_H: rd = half_read(DATA_W'(mask_reg), hi);
                    REG_TYPE_L, REG_TYPE_H: rd = half_read(DATA_W'(type_reg), hi);
                    REG_POL_L, REG_POL_H:   rd = half_read(DATA_W'(pol_reg), hi);
                    REG_BOTH_L, REG_BOTH_H: rd = half_read(DATA_W'(both_reg), hi);
                    REG_STATUS:             rd = DATA_W'(raw_reg & ~mask_reg);
                    REG_RAW:                rd = DATA_W'(raw_reg);
                    REG_EXT_PORT:           rd = DATA_W'(last_reg);
                    default: ;
                endcase
            end
            CMD_SAMPLE: begin
                raw_next  = sample_raw & enable_reg;
                last_next = cur;
            end
            default: ;
        endcase
    end

    assign rsp.read_data = rd;
    assign rsp.irq_line  = |(raw_next & ~mask_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            mask_reg   <= '0;
            type_reg   <= '0;
            pol_reg    <= '0;
            both_reg   <= '0;
            raw_reg    <= '0;
            last_reg   <= '0;
        end else if (req_fire) begin
            enable_reg <= enable_next;
            mask_reg   <= mask_next;
            type_reg   <= type_next;
            pol_reg    <= pol_next;
            both_reg   <= both_next;
            raw_reg    <= raw_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ===== sv/gpio_interrupt_controller.sv =====
// top level of the gpio interrupt controller: handshake and result register
// depends on gpioic_pkg and gpioic_core
`timescale 1ns / 1ps

// channel  | direction | word carried
// s_*      | in        | command, reg_word, write_data, pin_levels
// m_*      | out       | read_data, irq_line
//
// one word accepted per clock while the result slot is free; the result register
// loads on accept, from the single pass through register and detection logic
// aresetn is synchronous, active low; clears the core registers and result valid
// a stalled result holds; s_ready stays high while the result is empty or taken
// the same cycle, so a new word enters while the previous one leaves

module gpio_interrupt_controller #(
    parameter int PIN_COUNT = gpioic_pkg::PIN_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gpioic_pkg::CMD_W-1:0]    s_command,
    input  logic [gpioic_pkg::WORD_W-1:0]   s_reg_word,
    input  logic [gpioic_pkg::DATA_W-1:0]   s_write_data,
    input  logic [gpioic_pkg::DATA_W-1:0]   s_pin_levels,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gpioic_pkg::DATA_W-1:0]   m_read_data,
    output logic                            m_irq_line
);
    import gpioic_pkg::*;

    req_t              req;
    rsp_t              rsp;
    logic              s_fire;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] read_data_reg;
    logic              irq_reg;

    // gather the input word into one request
    assign req.command    = cmd_t'(s_command);
    assign req.reg_word   = s_reg_word;
    assign req.write_data = s_write_data;
    assign req.pin_levels = s_pin_levels;

    // accept whenever the result slot is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // register state and detection; state commits on accept
    gpioic_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_fire (s_fire),
        .req      (req),
        .rsp      (rsp)
    );

    // result valid: set by an accepted word, cleared once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only on accept so a stall holds it
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            read_data_reg <= rsp.read_data;
            irq_reg       <= rsp.irq_line;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = read_data_reg;
    assign m_irq_line  = irq_reg;

endmodule

// ===== sv/gpioic_checker.sv =====
// port-level checks on the gpio interrupt controller, bound to the top level
// depends on gpioic_pkg and gpio_interrupt_controller_defines.svh
`timescale 1ns / 1ps
`include "gpio_interrupt_controller_defines.svh"

module gpioic_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [gpioic_pkg::CMD_W-1:0]    s_command,
    input logic [gpioic_pkg::WORD_W-1:0]   s_reg_word,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [gpioic_pkg::DATA_W-1:0]   m_read_data,
    input logic                            m_irq_line
);
    import gpioic_pkg::*;

    // a stalled result keeps its word
    `GPIOIC_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_read_data) && $stable(m_irq_line))

    // every accepted word gives a result next cycle
    `GPIOIC_ASSERT_NEXT(a_word_gives_result, s_valid && s_ready, m_valid)

    // an empty result slot never blocks the input side
    `GPIOIC_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

    // only reads return data
    `GPIOIC_ASSERT_NEXT(a_nonread_zero, s_valid && s_ready && (s_command != CMD_READ),
        m_read_data == '0)

    // unmapped word reads zero
    `GPIOIC_ASSERT_NEXT(a_unmapped_zero,
        s_valid && s_ready && (s_command == CMD_READ) && (s_reg_word == '0),
        m_read_data == '0)

endmodule

bind gpio_interrupt_controller gpioic_checker u_gpioic_checker (.*);

// ===== sim/gpio_interrupt_controller_tb.sv =====
// self-checking testbench for gpio_interrupt_controller: directed and random words
// depends on gpioic_pkg and the gpio_interrupt_controller rtl
`timescale 1ns / 1ps

module gpio_interrupt_controller_tb;
    import gpioic_pkg::*;

    localparam int PINS = PIN_COUNT_DEF;
    localparam logic [DATA_W-1:0] PIN_MASK = {DATA_W{1'b1}} >> (DATA_W - PINS);
    localparam int IDLE_PCT      = 26;   // chance per cycle that a side idles
    localparam int HOLD_CYCLES   = 64;   // receiver hold-off for the back-pressure test
    localparam int SETTLE_CYCLES = 8;    // drain time after the last expected word
    localparam int MAX_PRINTS    = 40;
    localparam logic [WORD_W-1:0] REG_UNUSED = 5'd31;   // no register at this word

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [WORD_W-1:0]   s_reg_word;
    logic [DATA_W-1:0]   s_write_data;
    logic [DATA_W-1:0]   s_pin_levels;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_read_data;
    logic                m_irq_line;

    gpio_interrupt_controller #(
        .PIN_COUNT (PINS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_reg_word   (s_reg_word),
        .s_write_data (s_write_data),
        .s_pin_levels (s_pin_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_line   (m_irq_line)
    );

    // shadow copy of the controller state, updated as each word is accepted
    logic [DATA_W-1:0] enable_sh, mask_sh, type_sh, polarity_sh, both_sh;
    logic [DATA_W-1:0] raw_sh, levels_sh;

    rsp_t expected_q[$];   // predicted read data and irq line, oldest first
    rsp_t want;
    int   err_count;
    int   result_count;

    // shared between the test sequence and the receiver
    logic quiet;           // when set neither side idles
    logic hold_req;        // asks the receiver for one long hold-off
    int   hold_left;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // -------------------------------------------------------------------------
    // behaviour of the controller
    // -------------------------------------------------------------------------

    // a 16-bit value placed in the low or high half of the pin vector
    function automatic logic [DATA_W-1:0] place_half(logic [HALF_W-1:0] v, logic hi);
        return (hi ? {v, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, v}) & PIN_MASK;
    endfunction

    // bits 31:16 of the written word act as write enables for bits 15:0
    function automatic logic [DATA_W-1:0] merge_half(logic [DATA_W-1:0] cur,
                                                    logic [DATA_W-1:0] d, logic hi);
        logic [DATA_W-1:0] sel;
        logic [DATA_W-1:0] val;
        sel = place_half(d[DATA_W-1:HALF_W], hi);
        val = place_half(d[DATA_W-1:HALF_W] & d[HALF_W-1:0], hi);
        return ((cur & ~sel) | val) & PIN_MASK;
    endfunction

    function automatic logic [DATA_W-1:0] read_half(logic [DATA_W-1:0] r, logic hi);
        return hi ? {{HALF_W{1'b0}}, r[DATA_W-1:HALF_W]} : {{HALF_W{1'b0}}, r[HALF_W-1:0]};
    endfunction

    // applies one accepted word to the shadow state and queues its result
    task automatic apply_word(cmd_t c, logic [WORD_W-1:0] w, logic [DATA_W-1:0] d,
                              logic [DATA_W-1:0] p);
        rsp_t              res;
        logic [DATA_W-1:0] rd, cur, rise, fall, hit, edge_pins, lvl_pins, r;
        logic              hi;
        rd = '0;
        hi = w[0];
        case (c)
            CMD_WRITE: begin
                case (w)
                    REG_EN_L, REG_EN_H: begin
                        // disabling a pin drops its pending bit at once
                        enable_sh = merge_half(enable_sh, d, hi);
                        raw_sh    = raw_sh & enable_sh;
                    end
                    REG_MASK_L, REG_MASK_H: mask_sh     = merge_half(mask_sh, d, hi);
                    REG_TYPE_L, REG_TYPE_H: type_sh     = merge_half(type_sh, d, hi);
                    REG_POL_L, REG_POL_H:   polarity_sh = merge_half(polarity_sh, d, hi);
                    REG_BOTH_L, REG_BOTH_H: both_sh     = merge_half(both_sh, d, hi);
                    REG_EOI_L, REG_EOI_H: begin
                        // only edge latches are cleared, level pins follow the pin
                        raw_sh = raw_sh & ~(place_half(d[DATA_W-1:HALF_W] & d[HALF_W-1:0], hi)
                                            & (type_sh | both_sh));
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (w)
                    REG_EN_L, REG_EN_H:     rd = read_half(enable_sh, hi);
                    REG_MASK_L, REG_MASK_H: rd = read_half(mask_sh, hi);
                    REG_TYPE_L, REG_TYPE_H: rd = read_half(type_sh, hi);
                    REG_POL_L, REG_POL_H:   rd = read_half(polarity_sh, hi);
                    REG_BOTH_L, REG_BOTH_H: rd = read_half(both_sh, hi);
                    REG_STATUS:             rd = raw_sh & ~mask_sh & PIN_MASK;
                    REG_RAW:                rd = raw_sh & PIN_MASK;
                    REG_EXT_PORT:           rd = levels_sh & PIN_MASK;
                    default:                rd = '0;
                endcase
            end
            CMD_SAMPLE: begin
                cur       = p & PIN_MASK;
                rise      = cur & ~levels_sh;
                fall      = ~cur & levels_sh;
                hit       = (rise & polarity_sh) | (fall & ~polarity_sh);
                edge_pins = type_sh & ~both_sh;
                lvl_pins  = ~type_sh & ~both_sh;
                r         = raw_sh | (both_sh & (rise | fall)) | (edge_pins & hit);
                // level pins track the pin against its polarity on every sample
                r         = (r & ~lvl_pins) | (lvl_pins & ~(cur ^ polarity_sh));
                raw_sh    = r & enable_sh & PIN_MASK;
                levels_sh = cur;
            end
            default: ;
        endcase
        res.read_data = rd;
        res.irq_line  = |(raw_sh & ~mask_sh & PIN_MASK);
        expected_q.push_back(res);
    endtask

    // -------------------------------------------------------------------------
    // sender, receiver and result checking
    // -------------------------------------------------------------------------

    // offers one word, with a random gap first, and holds it until accepted
    task automatic send_word(cmd_t c, logic [WORD_W-1:0] w, logic [DATA_W-1:0] d,
                             logic [DATA_W-1:0] p);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (!quiet && $urandom_range(99) < IDLE_PCT);
        end
        s_valid      <= 1'b1;
        s_command    <= c;
        s_reg_word   <= w;
        s_write_data <= d;
        s_pin_levels <= p;
        do @(posedge aclk); while (!s_ready);
        apply_word(c, w, d, p);
    endtask

    // receiver: random stalls, or one long hold-off when the test asks
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] exp_val);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch at word %0d: %s got %h want %h", result_count, what,
                     got, exp_val);
    endtask

    // every result word taken is compared with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word, read_data", m_read_data, '0);
            end else begin
                want = expected_q.pop_front();
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", m_read_data, want.read_data);
                if (m_irq_line !== want.irq_line)
                    report_mismatch("irq_line", {31'd0, m_irq_line}, {31'd0, want.irq_line});
            end
            result_count++;
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------

    // named registers: the ten control halves first, then status, raw, eoi, port
    function automatic logic [WORD_W-1:0] named_reg(int k);
        case (k)
            0:       return REG_EN_L;
            1:       return REG_EN_H;
            2:       return REG_MASK_L;
            3:       return REG_MASK_H;
            4:       return REG_TYPE_L;
            5:       return REG_TYPE_H;
            6:       return REG_POL_L;
            7:       return REG_POL_H;
            8:       return REG_BOTH_L;
            9:       return REG_BOTH_H;
            10:      return REG_STATUS;
            11:      return REG_RAW;
            12:      return REG_EOI_L;
            13:      return REG_EOI_H;
            default: return REG_EXT_PORT;
        endcase
    endfunction

    // mostly a few pins toggling, so edges stay sparse; sometimes a fresh pattern
    function automatic logic [DATA_W-1:0] next_levels();
        case ($urandom_range(3))
            0:       return $urandom;
            default: return levels_sh ^ ($urandom & $urandom & $urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] ctrl_data();
        if ($urandom_range(7) == 0)
            return {{HALF_W{1'b1}}, HALF_W'($urandom)};
        return $urandom;
    endfunction

    task automatic random_words(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_word(CMD_SAMPLE, WORD_W'($urandom), $urandom, next_levels());
            else if (pick < 60)
                send_word(CMD_WRITE, named_reg($urandom_range(9)), ctrl_data(), $urandom);
            else if (pick < 75)
                send_word(CMD_READ, named_reg($urandom_range(14)), $urandom, $urandom);
            else if (pick < 85)
                send_word(CMD_WRITE, named_reg($urandom_range(12, 13)), $urandom, $urandom);
            else
                // noise: any command at any word offset, no-op command included
                send_word(cmd_t'($urandom_range(3)), WORD_W'($urandom_range(31)),
                          $urandom, $urandom);
        end
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // half writes with and without write enables, ignored writes, unused words
    task automatic test_register_access();
        send_word(CMD_READ,  REG_EN_L,   '0, '0);
        send_word(CMD_WRITE, REG_EN_L,   32'hFFFF_FFFF, '0);
        send_word(CMD_WRITE, REG_EN_H,   32'h0001_0001, '0);
        send_word(CMD_WRITE, REG_EN_H,   32'h0000_FFFF, '0);     // no enables, no effect
        send_word(CMD_READ,  REG_EN_H,   '0, '0);
        send_word(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF, '0);     // status is read only
        send_word(CMD_READ,  REG_UNUSED, '0, '0);                // unused word reads zero
        send_word(CMD_NOP,   REG_EN_L,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, REG_EN_H,   32'hFFFF_FFFF, '0);
    endtask

    // level pins, active low after reset; first sample compares against zero
    task automatic test_level_detect();
        send_word(CMD_SAMPLE, '0,          '0, 32'hFFFF_FFFF);
        send_word(CMD_SAMPLE, '0,          '0, 32'h0000_FFFF);
        send_word(CMD_READ,   REG_RAW,     '0, '0);
        send_word(CMD_READ,   REG_EXT_PORT, '0, '0);
    endtask

    // edge and both-edge latching, then end of interrupt on parts of each half
    task automatic test_edge_latch_and_clear();
        send_word(CMD_WRITE,  REG_TYPE_L, 32'hFFFF_FFFF, '0);
        send_word(CMD_WRITE,  REG_TYPE_H, 32'hFFFF_FFFF, '0);
        send_word(CMD_WRITE,  REG_POL_L,  32'hFFFF_FFFF, '0);
        send_word(CMD_WRITE,  REG_BOTH_H, 32'hFFFF_00F0, '0);
        send_word(CMD_SAMPLE, '0,         '0, 32'h0000_0000);
        send_word(CMD_SAMPLE, '0,         '0, 32'hFFFF_FFFF);
        send_word(CMD_WRITE,  REG_EOI_L,  32'hFFFF_000F, '0);
        send_word(CMD_WRITE,  REG_EOI_H,  32'h0001_0001, '0);
        send_word(CMD_READ,   REG_RAW,    '0, '0);
    endtask

    // masking hides pending pins from status and irq; disabling clears them
    task automatic test_mask_and_disable();
        send_word(CMD_WRITE, REG_MASK_L, 32'hFFFF_FFFF, '0);
        send_word(CMD_READ,  REG_STATUS, '0, '0);
        send_word(CMD_WRITE, REG_EN_H,   32'hFFFF_0000, '0);
        send_word(CMD_READ,  REG_RAW,    '0, '0);
    endtask

    // receiver holds off while words keep coming, so the input has to stall
    task automatic test_backpressure();
        quiet    = 1'b1;
        hold_req = 1'b1;
        random_words(48);
        quiet    = 1'b0;
    endtask

    // random traffic, with a stretch in the middle where nobody idles
    task automatic test_random_mix();
        random_words(600);
        quiet = 1'b1;
        random_words(300);
        quiet = 1'b0;
        random_words(450);
    endtask

    // -------------------------------------------------------------------------
    // sequence
    // -------------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_NOP;
        s_reg_word   = '0;
        s_write_data = '0;
        s_pin_levels = '0;
        m_ready      = 1'b0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        err_count    = 0;
        result_count = 0;
        enable_sh    = '0;
        mask_sh      = '0;
        type_sh      = '0;
        polarity_sh  = '0;
        both_sh      = '0;
        raw_sh       = '0;
        levels_sh    = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_level_detect();
        test_edge_latch_and_clear();
        test_mask_and_disable();
        test_backpressure();
        test_random_mix();

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_count == 0 && expected_q.size() == 0) begin
            $display("gpio_interrupt_controller_tb: clean");
        end else begin
            $display("gpio_interrupt_controller_tb: errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #(4_000_000);
        $display("gpio_interrupt_controller_tb: errors");
        $finish;
    end

endmodule
